[hw/rtl/cdq_pkg.sv]
package cdq_pkg;

  // Ring capacity and the widths that follow from it.
  localparam int unsigned DEPTH = 256;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned COORD_W = 16;

  // Packed beat widths, padded to whole bytes.
  localparam int unsigned IN_BITS = 3 + 2 * COORD_W;
  localparam int unsigned IN_W = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS = 2 + 6 * COORD_W + 1 + CNT_W;
  localparam int unsigned OUT_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_REM_HEAD = 3'd2,
    OP_REM_TAIL = 3'd3,
    OP_SEARCH   = 3'd4,
    OP_CLEAR    = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_RD_HEAD,
    S_RD_TAIL,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } coord_t;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Ring position a + b, both below DEPTH.
  function automatic idx_t ring_add(idx_t a, idx_t b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W + 1)'(DEPTH)) begin
      s = s - (IDX_W + 1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

[hw/rtl/cdq_ram.sv]
module cdq_ram (
  input  logic            clk_i,
  input  logic            we_i,
  input  cdq_pkg::idx_t   waddr_i,
  input  cdq_pkg::coord_t wdata_i,
  input  cdq_pkg::idx_t   raddr_i,
  output cdq_pkg::coord_t rdata_o
);
  import cdq_pkg::*;

  coord_t mem_q [DEPTH];
  coord_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/coordinate_deque_with_search.sv]
// Bounded double-ended queue of (x, y) coordinate pairs with a membership search.
// Input beats carry one operation each: insert at head or tail, remove from head
// or tail, search for a pair, or clear. Every input beat yields exactly one output
// beat holding the status, the removed pair, the search flag, the head and tail
// pairs after the operation and the queue length.
// The entries live in a single ring memory with one write and one read port and a
// registered read; a small sequencer drives that port for every operation.
// Inserts, removals, clear and unused codes pass from input acceptance through the
// execute, head-read, tail-read and finish steps to the output beat. A search adds
// a scan step that reads one stored entry per cycle through the same read port;
// it stops early on the first match.
// The block takes one operation at a time: s_tready_o is high only while the
// sequencer is idle. The output register frees the sequencer, so a new beat can be
// accepted while the previous result waits; the sequencer then holds in its last
// step until the receiver takes that result.
// Reset empties the queue (length zero, head at ring position zero) and drops any
// pending result. The memory contents are not cleared and need no clearing pass.
module coordinate_deque_with_search (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_tvalid_i,
  output logic                      s_tready_o,
  // Fields from bit 0 up: operation[2:0], in_x[15:0], in_y[15:0], zero pad.
  input  logic [cdq_pkg::IN_W-1:0]  s_tdata_i,
  output logic                      m_tvalid_o,
  input  logic                      m_tready_i,
  // Fields from bit 0 up: status[1:0], removed_x, removed_y, found, head_x,
  // head_y, tail_x, tail_y (16 bits each but found), length[8:0], zero pad.
  output logic [cdq_pkg::OUT_W-1:0] m_tdata_o
);
  import cdq_pkg::*;

  state_e  state_q, state_d;
  op_e     op_q, op_d;
  coord_t  tgt_q, tgt_d;
  idx_t    head_q, head_d;
  cnt_t    count_q, count_d;
  cnt_t    k_q, k_d;
  logic    pend_q, pend_d;
  status_e status_q, status_d;
  logic    found_q, found_d;
  coord_t  rem_q, rem_d;
  coord_t  hpair_q, hpair_d;
  logic [OUT_W-1:0] out_q, out_d;
  logic    out_valid_q, out_valid_d;

  // Memory port.
  logic   we;
  idx_t   waddr;
  coord_t wdata;
  idx_t   raddr;
  coord_t rdata;

  cdq_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic   is_full, is_empty, rem_ok;
  idx_t   tail_idx;
  coord_t tail_pair, head_out;

  assign is_full  = (count_q == CNT_W'(DEPTH));
  assign is_empty = (count_q == '0);
  // Ring position of the last occupied entry; only meaningful when not empty.
  assign tail_idx = ring_add(head_q, idx_t'(count_q - CNT_W'(1)));
  assign rem_ok   = (op_q == OP_REM_HEAD || op_q == OP_REM_TAIL) && (status_q == ST_OK);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    tgt_d       = tgt_q;
    head_d      = head_q;
    count_d     = count_q;
    k_d         = k_q;
    pend_d      = pend_q;
    status_d    = status_q;
    found_d     = found_q;
    rem_d       = rem_q;
    hpair_d     = hpair_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    we          = 1'b0;
    waddr       = head_q;
    wdata       = tgt_q;
    raddr       = tail_idx;
    tail_pair   = '0;
    head_out    = '0;

    if (out_valid_q && m_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          op_d    = op_e'(s_tdata_i[2:0]);
          tgt_d.x = s_tdata_i[3 +: COORD_W];
          tgt_d.y = s_tdata_i[3 + COORD_W +: COORD_W];
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        status_d = ST_OK;
        found_d  = 1'b0;
        rem_d    = '0;
        state_d  = S_RD_HEAD;
        case (op_q)
          OP_INS_HEAD: begin
            if (is_full) begin
              status_d = ST_FULL;
            end else begin
              head_d  = (head_q == '0) ? idx_t'(DEPTH - 1) : head_q - idx_t'(1);
              we      = 1'b1;
              waddr   = head_d;
              count_d = count_q + CNT_W'(1);
            end
          end
          OP_INS_TAIL: begin
            if (is_full) begin
              status_d = ST_FULL;
            end else begin
              we      = 1'b1;
              waddr   = ring_add(head_q, idx_t'(count_q));
              count_d = count_q + CNT_W'(1);
            end
          end
          OP_REM_HEAD: begin
            if (is_empty) begin
              status_d = ST_EMPTY;
            end else begin
              // The read uses the old head; the pair is taken in the next step.
              raddr   = head_q;
              head_d  = (head_q == idx_t'(DEPTH - 1)) ? '0 : head_q + idx_t'(1);
              count_d = count_q - CNT_W'(1);
            end
          end
          OP_REM_TAIL: begin
            if (is_empty) begin
              status_d = ST_EMPTY;
            end else begin
              raddr   = tail_idx;
              count_d = count_q - CNT_W'(1);
            end
          end
          OP_SEARCH: begin
            k_d     = '0;
            pend_d  = 1'b0;
            state_d = S_SCAN;
          end
          OP_CLEAR: begin
            head_d  = '0;
            count_d = '0;
          end
          default: begin
          end
        endcase
      end

      S_SCAN: begin
        // One read is issued per cycle; its data is compared in the following cycle.
        if (pend_q && rdata == tgt_q) begin
          found_d = 1'b1;
          pend_d  = 1'b0;
          state_d = S_RD_HEAD;
        end else if (k_q == count_q) begin
          pend_d  = 1'b0;
          state_d = S_RD_HEAD;
        end else begin
          raddr  = ring_add(head_q, idx_t'(k_q));
          k_d    = k_q + CNT_W'(1);
          pend_d = 1'b1;
        end
      end

      S_RD_HEAD: begin
        if (rem_ok) begin
          rem_d = rdata;
        end
        raddr   = head_q;
        state_d = S_RD_TAIL;
      end

      S_RD_TAIL: begin
        hpair_d = rdata;
        raddr   = tail_idx;
        state_d = S_FIN;
      end

      S_FIN: begin
        // Read address stays on the tail, so the read data holds while stalled.
        raddr = tail_idx;
        if (!out_valid_q || m_tready_i) begin
          if (!is_empty) begin
            tail_pair = rdata;
            head_out  = hpair_q;
          end
          out_d = '0;
          out_d[1:0]                    = status_q;
          out_d[2 +: COORD_W]           = rem_q.x;
          out_d[2 + COORD_W +: COORD_W] = rem_q.y;
          out_d[2 + 2 * COORD_W]        = found_q;
          out_d[3 + 2 * COORD_W +: COORD_W] = head_out.x;
          out_d[3 + 3 * COORD_W +: COORD_W] = head_out.y;
          out_d[3 + 4 * COORD_W +: COORD_W] = tail_pair.x;
          out_d[3 + 5 * COORD_W +: COORD_W] = tail_pair.y;
          out_d[3 + 6 * COORD_W +: CNT_W]   = count_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    tgt_q    <= tgt_d;
    k_q      <= k_d;
    status_q <= status_d;
    found_q  <= found_d;
    rem_q    <= rem_d;
    hpair_q  <= hpair_d;
    out_q    <= out_d;
  end

  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_q;

endmodule

[test/tb_coordinate_deque_with_search.sv]
module tb_coordinate_deque_with_search;
  timeunit 1ns;
  timeprecision 1ps;

  import cdq_pkg::*;

  // Stimulus stops once about this many input beats have been accepted.
  localparam int unsigned ITEM_TARGET = 1600;
  // Cycles without any beat on either side before the run is declared hung.
  // The slowest legal gap is a full-queue search during a long receiver hold.
  localparam int unsigned STALL_LIMIT = 3000;
  // Length of the long receiver hold-off that fills the block and stalls its input.
  localparam int unsigned HOLD_CYCLES = 300;
  // Quiet time after the last result, a little above the worst search latency.
  localparam int unsigned DRAIN_CYCLES = 300;

  // Operation codes six and seven are unused by the block and act as no-ops.
  localparam logic [2:0] OP_NOP_LO = 3'd6;
  localparam logic [2:0] OP_NOP_HI = 3'd7;

  // One output beat, laid out as on m_tdata_o with the lowest field last.
  typedef struct packed {
    logic [CNT_W-1:0]   len;
    logic [COORD_W-1:0] ty;
    logic [COORD_W-1:0] tx;
    logic [COORD_W-1:0] hy;
    logic [COORD_W-1:0] hx;
    logic               found;
    logic [COORD_W-1:0] ry;
    logic [COORD_W-1:0] rx;
    logic [1:0]         st;
  } deque_result_t;

  // Shadow copy of the deque. It predicts the result of every accepted
  // operation and checks output beats against the oldest prediction.
  class coord_deque_tracker;
    logic [COORD_W-1:0] x_mem [DEPTH];
    logic [COORD_W-1:0] y_mem [DEPTH];
    int unsigned head_pos;
    int unsigned fill;
    deque_result_t awaited [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned n_search;
    int unsigned n_found;
    int unsigned n_full;
    int unsigned n_empty;
    int unsigned peak;

    function int unsigned slot(int unsigned off);
      return (head_pos + off) % DEPTH;
    endfunction

    function void peek(int unsigned off, output logic [COORD_W-1:0] px,
                       output logic [COORD_W-1:0] py);
      px = x_mem[slot(off)];
      py = y_mem[slot(off)];
    endfunction

    function void note_input(logic [2:0] op, logic [COORD_W-1:0] vx,
                             logic [COORD_W-1:0] vy);
      deque_result_t r;
      int unsigned p;
      int unsigned k;
      r = '0;
      r.st = ST_OK;
      case (op)
        OP_INS_HEAD, OP_INS_TAIL: begin
          if (fill >= DEPTH) begin
            r.st = ST_FULL;
            n_full++;
          end else begin
            if (op == OP_INS_HEAD) begin
              head_pos = (head_pos + DEPTH - 1) % DEPTH;
              p = head_pos;
            end else begin
              p = slot(fill);
            end
            x_mem[p] = vx;
            y_mem[p] = vy;
            fill++;
          end
        end
        OP_REM_HEAD, OP_REM_TAIL: begin
          if (fill == 0) begin
            r.st = ST_EMPTY;
            n_empty++;
          end else begin
            p = (op == OP_REM_HEAD) ? head_pos : slot(fill - 1);
            r.rx = x_mem[p];
            r.ry = y_mem[p];
            fill--;
            if (op == OP_REM_HEAD) begin
              head_pos = (head_pos + 1) % DEPTH;
            end
          end
        end
        OP_SEARCH: begin
          n_search++;
          for (k = 0; k < fill; k++) begin
            if (x_mem[slot(k)] == vx && y_mem[slot(k)] == vy) begin
              r.found = 1'b1;
              break;
            end
          end
          if (r.found) begin
            n_found++;
          end
        end
        OP_CLEAR: begin
          fill = 0;
          head_pos = 0;
        end
        default: begin
        end
      endcase
      if (fill != 0) begin
        r.hx = x_mem[head_pos];
        r.hy = y_mem[head_pos];
        r.tx = x_mem[slot(fill - 1)];
        r.ty = y_mem[slot(fill - 1)];
      end
      r.len = cnt_t'(fill);
      if (fill > peak) begin
        peak = fill;
      end
      awaited.push_back(r);
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
      errors++;
      if (errors <= 40) begin
        $display("mismatch at output beat %0d: %s is %h, expected %h",
                 checked, what, got, want);
      end
    endtask

    task check_beat(logic [OUT_W-1:0] beat);
      deque_result_t got;
      deque_result_t want;
      got = deque_result_t'(beat[OUT_BITS-1:0]);
      checked++;
      if (awaited.size() == 0) begin
        report("beat with nothing pending, length", 16'(got.len), 16'h0);
        return;
      end
      want = awaited.pop_front();
      if (got.st !== want.st) report("status", 16'(got.st), 16'(want.st));
      if (got.rx !== want.rx) report("removed_x", got.rx, want.rx);
      if (got.ry !== want.ry) report("removed_y", got.ry, want.ry);
      if (got.found !== want.found) report("found", 16'(got.found), 16'(want.found));
      if (got.hx !== want.hx) report("head_x", got.hx, want.hx);
      if (got.hy !== want.hy) report("head_y", got.hy, want.hy);
      if (got.tx !== want.tx) report("tail_x", got.tx, want.tx);
      if (got.ty !== want.ty) report("tail_y", got.ty, want.ty);
      if (got.len !== want.len) report("length", 16'(got.len), 16'(want.len));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid_i = 1'b0;
  logic s_tready_o;
  logic [IN_W-1:0] s_tdata_i = '0;
  logic m_tvalid_o;
  logic m_tready_i = 1'b0;
  logic [OUT_W-1:0] m_tdata_o;

  coord_deque_tracker tracker = new;

  // Shared between the stimulus and the receiver: idle gaps on or off for the
  // current phase, and a request for one long receiver hold-off.
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int unsigned beats_in = 0;

  coordinate_deque_with_search i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Coordinates lean on the extremes and a tiny pool of values, so that
  // duplicates and search hits on random pairs happen; the rest is uniform
  // so that every bit of both fields toggles.
  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 11))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4, 5, 6: return 16'($urandom_range(0, 3));
      default: return 16'($urandom());
    endcase
  endfunction

  // Offers one operation and waits for the input handshake. Valid stays high
  // across back-to-back beats; it drops when an idle gap is drawn or in settle().
  task automatic push_op(input logic [2:0] op, input logic [COORD_W-1:0] vx,
                         input logic [COORD_W-1:0] vy);
    int unsigned gap;
    logic [IN_W-1:0] beat;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    beat = '0;
    beat[2:0] = op;
    beat[3 +: COORD_W] = vx;
    beat[3 + COORD_W +: COORD_W] = vy;
    s_tvalid_i <= 1'b1;
    s_tdata_i <= beat;
    do @(posedge clk_i); while (!s_tready_o);
    tracker.note_input(op, vx, vy);
    beats_in++;
  endtask

  // Searches aim at a stored pair half of the time, at a pair one bit away
  // from a stored one some of the time, and otherwise at a random pair.
  task automatic push_search();
    int unsigned r;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    r = $urandom_range(0, 9);
    sx = rand_coord();
    sy = rand_coord();
    if (tracker.fill > 0 && r < 7) begin
      tracker.peek($urandom_range(0, tracker.fill - 1), sx, sy);
      if (r >= 5) begin
        if ($urandom_range(0, 1)) sx[$urandom_range(0, COORD_W - 1)] ^= 1'b1;
        else sy[$urandom_range(0, COORD_W - 1)] ^= 1'b1;
      end
    end
    push_op(OP_SEARCH, sx, sy);
  endtask

  // One random operation drawn by weight: inserts, removals, searches, and
  // the rest split between clear and the two unused codes.
  task automatic random_op(input int unsigned w_ins, input int unsigned w_rem,
                           input int unsigned w_srch, input int unsigned w_misc);
    int unsigned r;
    r = $urandom_range(0, w_ins + w_rem + w_srch + w_misc - 1);
    if (r < w_ins) begin
      push_op($urandom_range(0, 1) ? OP_INS_TAIL : OP_INS_HEAD, rand_coord(), rand_coord());
    end else if (r < w_ins + w_rem) begin
      push_op($urandom_range(0, 1) ? OP_REM_TAIL : OP_REM_HEAD, rand_coord(), rand_coord());
    end else if (r < w_ins + w_rem + w_srch) begin
      push_search();
    end else begin
      case ($urandom_range(0, 2))
        0: push_op(OP_CLEAR, rand_coord(), rand_coord());
        1: push_op(OP_NOP_LO, rand_coord(), rand_coord());
        default: push_op(OP_NOP_HI, rand_coord(), rand_coord());
      endcase
    end
  endtask

  // Stops offering until every pending result has been taken.
  task automatic settle();
    s_tvalid_i <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: a random wait before each result while idle gaps are on, and
  // one long hold-off when the stimulus asks for it. Ready stays high across
  // back-to-back results, so it is never lowered and raised in one step.
  initial begin
    int unsigned wait_cycles;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      wait_cycles = idle_on ? $urandom_range(0, 4) : 0;
      if (wait_cycles > 0) begin
        m_tready_i <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      m_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid_o);
      tracker.check_beat(m_tdata_o);
    end
  end

  // Watchdog: ends the run when neither side moves a beat for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no beat moved for %0d cycles", quiet);
    $display("status: fail");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned n;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Removals and a search on the empty queue, the unused
    // codes, inserts of the coordinate extremes at both ends (the first head
    // insert wraps the ring position below zero), searches that hit the head,
    // the tail and a middle entry, misses on one coordinate only, then clear,
    // a search for a pair that clear made stale, and a refill after clear.
    push_op(OP_REM_HEAD, 16'h0000, 16'h0000);
    push_op(OP_REM_TAIL, 16'hffff, 16'hffff);
    push_op(OP_SEARCH, 16'h0000, 16'h0000);
    push_op(OP_NOP_LO, 16'h1234, 16'h5678);
    push_op(OP_NOP_HI, 16'hedcb, 16'ha987);
    push_op(OP_INS_HEAD, 16'h7fff, 16'h8000);
    push_op(OP_INS_TAIL, 16'h8000, 16'h7fff);
    push_op(OP_INS_HEAD, 16'h0000, 16'h0000);
    push_op(OP_INS_TAIL, 16'hffff, 16'hffff);
    push_op(OP_SEARCH, 16'hffff, 16'hffff);
    push_op(OP_SEARCH, 16'h0000, 16'h0000);
    push_op(OP_SEARCH, 16'h8000, 16'h7fff);
    push_op(OP_SEARCH, 16'hffff, 16'hfffe);
    push_op(OP_SEARCH, 16'h7fff, 16'h7fff);
    push_op(OP_NOP_HI, 16'h0000, 16'h0000);
    push_op(OP_REM_HEAD, 16'h0000, 16'h0000);
    push_op(OP_REM_TAIL, 16'h0000, 16'h0000);
    push_op(OP_CLEAR, 16'hffff, 16'hffff);
    push_op(OP_SEARCH, 16'h8000, 16'h7fff);
    push_op(OP_REM_TAIL, 16'h0000, 16'h0000);
    push_op(OP_INS_TAIL, 16'h0001, 16'h0002);
    push_op(OP_REM_HEAD, 16'h0000, 16'h0000);
    push_op(OP_INS_HEAD, 16'haaaa, 16'h5555);
    push_op(OP_REM_TAIL, 16'h0000, 16'h0000);
    settle();

    // Random part in phases: fill to full and push against it, mix, drain to
    // empty and pull against it, mix again. Every fourth phase runs without
    // idle gaps, and each mixed phase asks the receiver for one long hold-off.
    phase = 0;
    while (beats_in < ITEM_TARGET) begin
      idle_on = (phase % 4) != 3;
      case (phase % 4)
        0: begin
          while (tracker.fill < DEPTH) random_op(80, 5, 15, 0);
          repeat (4) random_op(100, 0, 0, 0);
          push_search();
        end
        2: begin
          while (tracker.fill > 0) random_op(5, 80, 15, 0);
          repeat (2) random_op(0, 100, 0, 0);
          push_search();
        end
        default: begin
          for (n = 0; n < 120; n++) begin
            if (n == 30) hold_req = 1'b1;
            random_op(50, 24, 20, 6);
          end
        end
      endcase
      // The sender waits here until every result of the phase has arrived.
      settle();
      phase++;
    end

    idle_on = 1'b1;
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d operations, %0d results checked, peak length %0d",
             beats_in, tracker.checked, tracker.peak);
    $display("%0d searches with %0d hits, %0d full-queue drops, %0d empty removals",
             tracker.n_search, tracker.n_found, tracker.n_full, tracker.n_empty);
    if (tracker.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_ram.sv
hw/rtl/coordinate_deque_with_search.sv
test/tb_coordinate_deque_with_search.sv
